// ===== rtl/bc1_pkg.sv =====
// Package for the BC1 block decoder: RGB565 field positions, the reciprocal
// used for the divide by three and the palette word passed between stages.
// Depends on nothing; every rtl module refers to it by scoped names.
package bc1_pkg;

  localparam int unsigned ColourW  = 16;
  localparam int unsigned IdxW     = 32;
  localparam int unsigned Rows     = 4;
  localparam int unsigned Cols     = 4;
  localparam int unsigned RowW     = $clog2(Rows);
  localparam int unsigned SelW     = 2;
  localparam int unsigned RowBits  = Cols * SelW;

  localparam int unsigned BlueLsb  = 0;
  localparam int unsigned GreenLsb = 5;
  localparam int unsigned RedLsb   = 11;
  localparam int unsigned Ch5W     = 5;
  localparam int unsigned Ch6W     = 6;

  // Weighted sums of two channels fit in eight bits (3 * 63 = 189).
  localparam int unsigned SumW       = 8;
  // floor(x / 3) == (x * 171) >> 9 for every x below 256.
  localparam int unsigned RecipThird = 171;
  localparam int unsigned RecipShift = 9;
  localparam int unsigned RecipW     = 8;
  localparam int unsigned ProdW      = SumW + RecipW;

  localparam int unsigned NumCh = 3;

  typedef logic [ColourW-1:0] colour_t;
  typedef logic [Ch6W-1:0]    chan_t;

  // Palette of one block plus its index bits.
  typedef struct packed {
    colour_t [Rows-1:0] pal;
    logic [IdxW-1:0]    idx;
  } blk_t;

  // Channel k (0 blue, 1 green, 2 red) of an RGB565 word, zero extended.
  function automatic chan_t get_chan(input colour_t c, input int unsigned k);
    chan_t res;
    res = '0;
    unique case (k)
      0:       res = chan_t'(c[BlueLsb +: Ch5W]);
      1:       res = c[GreenLsb +: Ch6W];
      default: res = chan_t'(c[RedLsb +: Ch5W]);
    endcase
    return res;
  endfunction

  function automatic colour_t pack_rgb(input chan_t b, input chan_t g, input chan_t r);
    return {r[Ch5W-1:0], g, b[Ch5W-1:0]};
  endfunction

  function automatic chan_t div3(input logic [SumW-1:0] x);
    logic [ProdW-1:0] prod;
    prod = ProdW'(x) * ProdW'(RecipThird);
    return prod[RecipShift +: Ch6W];
  endfunction

endpackage

// ===== rtl/bc1_blend.sv =====
// Palette stages of the BC1 decoder: channel sums, then divide by three and
// palette selection. Depends on bc1_pkg.
module bc1_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         three_en_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bc1_pkg::ColourW-1:0]  endpoint_a_i,
  input  logic [bc1_pkg::ColourW-1:0]  endpoint_b_i,
  input  logic [bc1_pkg::IdxW-1:0]     index_bits_i,
  output logic                         blk_valid_o,
  input  logic                         blk_ready_i,
  output bc1_pkg::blk_t                blk_o
);

  logic                                            s1_valid_q, s2_valid_q;
  logic                                            s1_ready, s2_ready;
  bc1_pkg::colour_t                                s1_a_q, s1_b_q;
  logic [bc1_pkg::IdxW-1:0]                        s1_idx_q;
  logic                                            s1_tc_q, s1_tc_d;
  logic [bc1_pkg::NumCh-1:0][bc1_pkg::SumW-1:0]    s1_sa_q, s1_sa_d;
  logic [bc1_pkg::NumCh-1:0][bc1_pkg::SumW-1:0]    s1_sb_q, s1_sb_d;
  logic [bc1_pkg::NumCh-1:0][bc1_pkg::Ch6W-1:0]    s1_half_q, s1_half_d;
  bc1_pkg::blk_t                                   s2_q, s2_d;
  logic [bc1_pkg::NumCh-1:0][bc1_pkg::Ch6W-1:0]    p2, p3;

  assign s2_ready   = !s2_valid_q || blk_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage one: the weighted sums 2a+b, a+2b and the average a+b.
  always_comb begin
    logic [bc1_pkg::SumW-1:0] ca, cb;
    s1_tc_d = three_en_i && (endpoint_a_i <= endpoint_b_i);
    for (int k = 0; k < bc1_pkg::NumCh; k++) begin
      ca = bc1_pkg::SumW'(bc1_pkg::get_chan(endpoint_a_i, k));
      cb = bc1_pkg::SumW'(bc1_pkg::get_chan(endpoint_b_i, k));
      s1_sa_d[k]   = (ca << 1) + cb;
      s1_sb_d[k]   = ca + (cb << 1);
      s1_half_d[k] = bc1_pkg::Ch6W'((ca + cb) >> 1);
    end
  end

  // Stage two: divide by three and choose the palette form.
  always_comb begin
    for (int k = 0; k < bc1_pkg::NumCh; k++) begin
      p2[k] = s1_tc_q ? s1_half_q[k] : bc1_pkg::div3(s1_sa_q[k]);
      p3[k] = s1_tc_q ? '0 : bc1_pkg::div3(s1_sb_q[k]);
    end
    s2_d.pal[0] = s1_a_q;
    s2_d.pal[1] = s1_b_q;
    s2_d.pal[2] = bc1_pkg::pack_rgb(p2[0], p2[1], p2[2]);
    s2_d.pal[3] = bc1_pkg::pack_rgb(p3[0], p3[1], p3[2]);
    s2_d.idx    = s1_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_a_q    <= endpoint_a_i;
      s1_b_q    <= endpoint_b_i;
      s1_idx_q  <= index_bits_i;
      s1_tc_q   <= s1_tc_d;
      s1_sa_q   <= s1_sa_d;
      s1_sb_q   <= s1_sb_d;
      s1_half_q <= s1_half_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign blk_valid_o = s2_valid_q;
  assign blk_o       = s2_q;

endmodule

// ===== rtl/bc1_row_ser.sv =====
// Row serialiser of the BC1 decoder: holds one palette and emits the four
// rows through a registered output word. Depends on bc1_pkg.
module bc1_row_ser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         blk_valid_i,
  output logic                         blk_ready_o,
  input  bc1_pkg::blk_t                blk_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col0_o,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col1_o,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col2_o,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col3_o,
  output logic [bc1_pkg::RowW-1:0]     row_number_o,
  output logic                         last_row_o
);

  localparam logic [bc1_pkg::RowW-1:0] LastRow = bc1_pkg::RowW'(bc1_pkg::Rows - 1);

  logic                                          hold_valid_q;
  bc1_pkg::blk_t                                 hold_q;
  logic [bc1_pkg::RowW-1:0]                      row_q;
  logic                                          ov_q;
  bc1_pkg::colour_t [bc1_pkg::Cols-1:0]          pix_q, pix_d;
  logic [bc1_pkg::RowW-1:0]                      rown_q;
  logic                                          last_q;
  logic                                          out_load, hold_done, blk_take;
  logic [bc1_pkg::RowBits-1:0]                   row_idx;

  assign out_load    = hold_valid_q && (!ov_q || out_ready_i);
  assign hold_done   = out_load && (row_q == LastRow);
  assign blk_ready_o = !hold_valid_q || hold_done;
  assign blk_take    = blk_ready_o && blk_valid_i;

  assign row_idx = hold_q.idx[row_q * bc1_pkg::RowBits +: bc1_pkg::RowBits];

  always_comb begin
    for (int x = 0; x < bc1_pkg::Cols; x++) begin
      pix_d[x] = hold_q.pal[row_idx[x * bc1_pkg::SelW +: bc1_pkg::SelW]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      row_q        <= '0;
      ov_q         <= 1'b0;
    end else begin
      if (blk_take) begin
        hold_valid_q <= 1'b1;
        row_q        <= '0;
      end else if (out_load) begin
        hold_valid_q <= !hold_done;
        row_q        <= row_q + 1'b1;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_take) begin
      hold_q <= blk_i;
    end
    if (out_load) begin
      pix_q  <= pix_d;
      rown_q <= row_q;
      last_q <= (row_q == LastRow);
    end
  end

  assign out_valid_o  = ov_q;
  assign pixel_col0_o = pix_q[0];
  assign pixel_col1_o = pix_q[1];
  assign pixel_col2_o = pix_q[2];
  assign pixel_col3_o = pix_q[3];
  assign row_number_o = rown_q;
  assign last_row_o   = last_q;

`ifndef SYNTHESIS
  // A taken row that is not the last is followed at once by the next row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=> out_valid_o)
    else $error("row serialiser left a gap inside a block");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o |=>
      row_number_o == $past(row_number_o) + 1'b1)
    else $error("row numbers out of order within a block");

  // After the last row of a block the next word shown, if any, is row zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_row_o |=> !out_valid_o || row_number_o == '0)
    else $error("new block did not start at the top row");
`endif

endmodule

// ===== rtl/bc1_block_decoder.sv =====
// BC1 (DXT1) block decoder. Each input word is one compressed 4x4 block: two
// RGB565 endpoints and 32 bits of 2-bit palette indices. Each block yields four
// output words, one per pixel row, top row first, with the row number and a
// flag on the fourth row. Palette entries 2 and 3 are floor((2a+b)/3) and
// floor((a+2b)/3) per channel; with three_color_mode_enable set and a <= b
// they become the average of the endpoints and black. The pipeline has two
// palette stages, a row serialiser and a registered output word: a block passes
// the stage-one, stage-two and serialiser block registers before its first row
// reaches the output word. The serialiser emits one row per cycle from the block
// it holds while the output is not stalled, and the next block is taken in the
// same cycle as the previous block's last row is loaded into the output word.
// The configuration register (byte address 0) should be written only while
// no block is in flight.
module bc1_block_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Block input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bc1_pkg::ColourW-1:0]  endpoint_a_i,
  input  logic [bc1_pkg::ColourW-1:0]  endpoint_b_i,
  input  logic [bc1_pkg::IdxW-1:0]     index_bits_i,
  // Row output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col0_o,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col1_o,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col2_o,
  output logic [bc1_pkg::ColourW-1:0]  pixel_col3_o,
  output logic [bc1_pkg::RowW-1:0]     row_number_o,
  output logic                         last_row_o
);

  // Register index is the word address; only index zero exists.
  localparam logic RegThreeColour = 1'b0;

  logic          three_en_q;
  logic          cfg_wr;
  logic          blk_valid, blk_ready;
  bc1_pkg::blk_t blk;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_en_q <= 1'b0;
    end else if (cfg_wr && (paddr[2] == RegThreeColour)) begin
      three_en_q <= pwdata[0];
    end
  end

  // Reads of unknown addresses return zero.
  assign prdata = (paddr[2] == RegThreeColour) ? {31'b0, three_en_q} : 32'b0;

  bc1_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .three_en_i   (three_en_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .endpoint_a_i (endpoint_a_i),
    .endpoint_b_i (endpoint_b_i),
    .index_bits_i (index_bits_i),
    .blk_valid_o  (blk_valid),
    .blk_ready_i  (blk_ready),
    .blk_o        (blk)
  );

  bc1_row_ser u_row_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_valid_i  (blk_valid),
    .blk_ready_o  (blk_ready),
    .blk_i        (blk),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_col0_o (pixel_col0_o),
    .pixel_col1_o (pixel_col1_o),
    .pixel_col2_o (pixel_col2_o),
    .pixel_col3_o (pixel_col3_o),
    .row_number_o (row_number_o),
    .last_row_o   (last_row_o)
  );

endmodule

// ===== tb/sv/bc1_row_checker.sv =====
// Row checker for the BC1 block decoder: watches the configuration port and
// both word channels, predicts the four pixel rows of every accepted block
// and compares them with the decoder's output. Depends on bc1_pkg.
module bc1_row_checker #(
  parameter logic [2:0] ModeAddr = 3'd0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [2:0]                  paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic [31:0]                 prdata_i,
  input  logic                        pready_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [bc1_pkg::ColourW-1:0] endpoint_a_i,
  input  logic [bc1_pkg::ColourW-1:0] endpoint_b_i,
  input  logic [bc1_pkg::IdxW-1:0]    index_bits_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [bc1_pkg::ColourW-1:0] pixel_col0_i,
  input  logic [bc1_pkg::ColourW-1:0] pixel_col1_i,
  input  logic [bc1_pkg::ColourW-1:0] pixel_col2_i,
  input  logic [bc1_pkg::ColourW-1:0] pixel_col3_i,
  input  logic [bc1_pkg::RowW-1:0]    row_number_i,
  input  logic                        last_row_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 rows_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bc1_pkg::*;

  typedef enum logic [1:0] {MixNearA, MixNearB, MixHalf} mix_kind_e;

  typedef struct packed {
    colour_t [Cols-1:0]  px;
    logic [RowW-1:0]     row;
    logic                last;
  } row_word_t;

  row_word_t pixel_rows_q[$];
  logic      three_colour_q;

  function automatic int unsigned blend_chan(input int unsigned x, input int unsigned y,
                                             input mix_kind_e kind);
    case (kind)
      MixNearA: return (2 * x + y) / 3;
      MixNearB: return (x + 2 * y) / 3;
      default:  return (x + y) / 2;
    endcase
  endfunction

  function automatic colour_t mix_colours(input colour_t a, input colour_t b,
                                          input mix_kind_e kind);
    int unsigned cb, cg, cr;
    cb = blend_chan(32'(a[BlueLsb +: Ch5W]), 32'(b[BlueLsb +: Ch5W]), kind);
    cg = blend_chan(32'(a[GreenLsb +: Ch6W]), 32'(b[GreenLsb +: Ch6W]), kind);
    cr = blend_chan(32'(a[RedLsb +: Ch5W]), 32'(b[RedLsb +: Ch5W]), kind);
    return {cr[Ch5W-1:0], cg[Ch6W-1:0], cb[Ch5W-1:0]};
  endfunction

  function automatic colour_t palette_colour(input colour_t a, input colour_t b,
                                             input logic three_on, input logic [SelW-1:0] sel);
    logic three_active;
    three_active = three_on && (a <= b);
    case (sel)
      2'd0:    return a;
      2'd1:    return b;
      2'd2:    return three_active ? mix_colours(a, b, MixHalf) : mix_colours(a, b, MixNearA);
      default: return three_active ? '0 : mix_colours(a, b, MixNearB);
    endcase
  endfunction

  task automatic note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_word_t        want, got;
    logic [SelW-1:0]  sel;
    if (!rst_ni) begin
      three_colour_q = 1'b0;
      pixel_rows_q.delete();
      fail_count_o   = 0;
      rows_pending_o = 0;
    end else begin
      // Register writes land here; reads of the mode register are checked.
      if (psel_i && penable_i && pready_i && paddr_i == ModeAddr) begin
        if (pwrite_i) begin
          three_colour_q = pwdata_i[0];
        end else if (prdata_i != {31'b0, three_colour_q}) begin
          note_failure($sformatf("mode read: expected %08h, got %08h",
                                 {31'b0, three_colour_q}, prdata_i));
        end
      end

      if (in_valid_i && in_ready_i) begin
        for (int r = 0; r < Rows; r++) begin
          for (int x = 0; x < Cols; x++) begin
            sel = index_bits_i[r * RowBits + x * SelW +: SelW];
            want.px[x] = palette_colour(endpoint_a_i, endpoint_b_i, three_colour_q, sel);
          end
          want.row  = RowW'(r);
          want.last = (r == Rows - 1);
          pixel_rows_q.push_back(want);
        end
      end

      if (out_valid_i && out_ready_i) begin
        got.px   = {pixel_col3_i, pixel_col2_i, pixel_col1_i, pixel_col0_i};
        got.row  = row_number_i;
        got.last = last_row_i;
        if (pixel_rows_q.size() == 0) begin
          note_failure($sformatf("unexpected row word: px %04h %04h %04h %04h row %0d last %0b",
                                 got.px[0], got.px[1], got.px[2], got.px[3],
                                 got.row, got.last));
        end else begin
          want = pixel_rows_q.pop_front();
          if (got != want) begin
            note_failure($sformatf({"row mismatch: expected px %04h %04h %04h %04h row %0d ",
                                    "last %0b, got px %04h %04h %04h %04h row %0d last %0b"},
                                   want.px[0], want.px[1], want.px[2], want.px[3],
                                   want.row, want.last,
                                   got.px[0], got.px[1], got.px[2], got.px[3],
                                   got.row, got.last));
          end
        end
      end
      rows_pending_o = pixel_rows_q.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the BC1 block decoder testbench: clock, reset, configuration
// writes and block stimulus, with the row checker beside the decoder.
// Depends on bc1_pkg, bc1_block_decoder and bc1_row_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bc1_pkg::*;

  // The mode register is register 0; address 4 holds no register at all, so a
  // write there must leave the mode untouched.
  localparam logic [2:0]  ModeAddr     = 3'd0;
  localparam logic [2:0]  SpareAddr    = 3'd4;
  localparam int unsigned RandomBlocks = 200;
  localparam int unsigned PhaseBlocks  = RandomBlocks / 4;
  localparam int unsigned IdlePct      = 17;
  localparam int unsigned DrainCycles  = 8;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [2:0]        paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  colour_t           endpoint_a_i  = '0;
  colour_t           endpoint_b_i  = '0;
  logic [IdxW-1:0]   index_bits_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  colour_t           pixel_col0_o, pixel_col1_o, pixel_col2_o, pixel_col3_o;
  logic [RowW-1:0]   row_number_o;
  logic              last_row_o;

  int unsigned       fail_count;
  int unsigned       rows_pending;

  // Random idling on either side can be switched off to give a stretch at
  // full rate.
  logic              gaps_on   = 1'b1;
  logic              stalls_on = 1'b1;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  bc1_block_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .endpoint_a_i (endpoint_a_i),
    .endpoint_b_i (endpoint_b_i),
    .index_bits_i (index_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_col0_o (pixel_col0_o),
    .pixel_col1_o (pixel_col1_o),
    .pixel_col2_o (pixel_col2_o),
    .pixel_col3_o (pixel_col3_o),
    .row_number_o (row_number_o),
    .last_row_o   (last_row_o)
  );

  bc1_row_checker #(
    .ModeAddr (ModeAddr)
  ) i_row_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .endpoint_a_i   (endpoint_a_i),
    .endpoint_b_i   (endpoint_b_i),
    .index_bits_i   (index_bits_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_col0_i   (pixel_col0_o),
    .pixel_col1_i   (pixel_col1_o),
    .pixel_col2_i   (pixel_col2_o),
    .pixel_col3_i   (pixel_col3_o),
    .row_number_i   (row_number_o),
    .last_row_i     (last_row_o),
    .fail_count_o   (fail_count),
    .rows_pending_o (rows_pending)
  );

  // The row receiver refuses a word in about 17 percent of cycles while stalls
  // are enabled, and is always ready otherwise.
  always @(posedge clk_i) begin
    out_ready_i <= !(stalls_on && $urandom_range(0, 99) < IdlePct);
  end

  // One register access: a setup phase, then an access phase that completes
  // at the first edge with pready high, then an idle gap so that the next
  // access starts cleanly. Every task here is entered just after a rising
  // edge, so all inputs change only at rising edges.
  task automatic apb_access(input logic write_en, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offers one block word, after a random number of idle cycles when gaps are
  // enabled. Valid is left high on return so that a back-to-back word keeps
  // it high; the caller lowers it once the stream is over.
  task automatic send_block(input colour_t a, input colour_t b, input logic [IdxW-1:0] idx);
    while (gaps_on && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    endpoint_a_i <= a;
    endpoint_b_i <= b;
    index_bits_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Random block with a shape chosen so that equal endpoints, ordered pairs
  // (which select the three-colour palette when enabled) and extreme colours
  // all turn up often.
  task automatic send_random_block();
    colour_t a, b, t;
    a = colour_t'($urandom);
    b = colour_t'($urandom);
    case ($urandom_range(0, 4))
      0: b = a;
      1: if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      2: begin
        a = $urandom_range(0, 1) ? '1 : '0;
        b = $urandom_range(0, 1) ? '1 : b;
      end
      default: ;
    endcase
    send_block(a, b, $urandom);
  endtask

  // Lowers valid and waits until every predicted row word has arrived, plus a
  // short margin so that the decoder is idle before the register changes.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (rows_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic three_on);
    apb_access(1'b1, ModeAddr, {31'($urandom_range(0, 32'h7FFF_FFFF)), three_on});
    apb_access(1'b0, ModeAddr, '0);
  endtask

  task automatic send_directed_blocks();
    send_block(16'h0000, 16'h0000, 32'h0000_0000);
    send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
    send_block(16'h0000, 16'hFFFF, 32'h1B1B_1B1B);
    send_block(16'h1234, 16'h1234, 32'hE4E4_E4E4);
    send_block(16'hF800, 16'h07E0, 32'hAAAA_AAAA);
    send_block(16'h001F, 16'hF800, 32'h5555_5555);
    send_block(16'hFFFE, 16'hFFFF, 32'h1BE4_E41B);
    send_block(16'h7BEF, 16'h8410, 32'h0F0F_F0F0);
    send_block(16'h8410, 16'h7BEF, 32'hC936_5AA5);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed blocks with the mode as left by reset: four-colour palette.
    apb_access(1'b0, ModeAddr, '0);
    send_directed_blocks();
    drain();

    // Upper data bits must be ignored, and a write to the spare address
    // must not reach the mode register.
    apb_access(1'b1, ModeAddr, 32'hFFFF_FFFE);
    apb_access(1'b1, SpareAddr, 32'hFFFF_FFFF);
    apb_access(1'b0, ModeAddr, '0);
    send_block(16'h0000, 16'hFFFF, 32'hFFAA_55E4);
    drain();

    // Three-colour mode: ordered, equal and reversed endpoint pairs.
    apb_access(1'b1, ModeAddr, 32'hFFFF_FFFF);
    apb_access(1'b0, ModeAddr, '0);
    send_directed_blocks();
    drain();

    // Random phases set the mode off, on, on and off; the third phase runs without any
    // idling on either side.
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase == 1 || phase == 2);
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);
      for (int n = 0; n < PhaseBlocks; n++) send_random_block();
      drain();
    end

    if (fail_count == 0 && rows_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
